>>> hw/rtl/uri_component_splitter_core_defines.svh
// Assertion macros shared by the URI splitter RTL.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef URI_COMPONENT_SPLITTER_CORE_DEFINES_SVH
`define URI_COMPONENT_SPLITTER_CORE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define UCS_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define UCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ucs_pkg.sv
// Package for the URI component splitter: payload types, character codes
// and character classes. No dependencies.
`default_nettype none

package ucs_pkg;

	localparam int CHAR_W = 8;
	localparam int OFF_W  = 13;

	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_QUEST = 8'h3F;
	localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;

	typedef struct packed {
		logic [CHAR_W-1:0] char_in;
		logic              last_char;
		logic              empty_uri;
	} char_item_t;

	typedef struct packed {
		logic             scheme_found;
		logic             scheme_relative;
		logic [OFF_W-1:0] scheme_end;
		logic             authority_present;
		logic [OFF_W-1:0] path_start;
		logic [OFF_W-1:0] query_start;
		logic [OFF_W-1:0] fragment_start;
		logic [OFF_W-1:0] total_length;
		logic             too_long;
	} result_item_t;

	function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_scheme_char(input logic [CHAR_W-1:0] c);
		return is_alpha(c) || ((c >= 8'h30) && (c <= 8'h39))
			|| (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_DOT);
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ucs_char_if.sv
// Byte channel into the URI splitter: valid, ready and one character item.
// Depends on ucs_pkg.
`default_nettype none

interface ucs_char_if;
	logic                valid;
	logic                ready;
	ucs_pkg::char_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ucs_result_if.sv
// Result channel out of the URI splitter: valid, ready and one result item.
// Depends on ucs_pkg.
`default_nettype none

interface ucs_result_if;
	logic                  valid;
	logic                  ready;
	ucs_pkg::result_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/uri_component_splitter_core.sv
// URI component splitter: input register, per-byte phase update, result register.
// Depends on ucs_pkg, ucs_char_if, ucs_result_if and the assertion macro header.
// Throughput: one byte per cycle through the phase state machine step, unless the input stalls.
// The last byte (or empty item) passes through the input register, then its result is loaded
// into the result register, from which it can be taken.
// The input stalls only when an end-of-URI transaction meets a result that still waits.
// Reset: arst_n clears the parse state, the input register valid and the result valid.
`default_nettype none
`include "uri_component_splitter_core_defines.svh"

module uri_component_splitter_core #(
	parameter int MAX_LEN = 4096
) (
	input  wire          clk,
	input  wire          arst_n,
	ucs_char_if.sink     chars,
	ucs_result_if.source result
);

	localparam int PW = $clog2(MAX_LEN + 1);
	localparam logic [PW-1:0] MAX_POS = PW'(MAX_LEN);

	localparam logic [3:0] PH_START  = 4'd0;
	localparam logic [3:0] PH_SLASH1 = 4'd1;
	localparam logic [3:0] PH_SCHEME = 4'd2;
	localparam logic [3:0] PH_AFTER0 = 4'd3;
	localparam logic [3:0] PH_AFTER1 = 4'd4;
	localparam logic [3:0] PH_AUTH   = 4'd5;
	localparam logic [3:0] PH_PATH   = 4'd6;
	localparam logic [3:0] PH_QUERY  = 4'd7;
	localparam logic [3:0] PH_FRAG   = 4'd8;

	// input stage
	logic                valid_s1;
	ucs_pkg::char_item_t item_s1;

	// parse state
	logic [3:0]    phase_q;
	logic [PW-1:0] bp_q, sch_q, path_q, qry_q, frag_q;
	logic          fl_scheme_q, fl_dslash_q, fl_long_q;

	// result register
	logic                  out_valid_q;
	ucs_pkg::result_item_t out_q;

	logic adv;

	// next parse state
	logic [3:0]    n_phase;
	logic [PW-1:0] n_bp, n_sch, n_path, n_qry, n_frag;
	logic          n_scheme, n_dslash, n_long;
	logic          to_path;
	logic [PW-1:0] pos;
	logic [ucs_pkg::CHAR_W-1:0] c;

	// end-of-URI values
	logic [PW-1:0] f_path, f_qry, f_frag;
	logic          f_auth;
	ucs_pkg::result_item_t fin;

	// Advance the input stage; an end-of-URI byte also needs room in the result register.
	assign adv         = valid_s1 && (!(item_s1.empty_uri || item_s1.last_char)
		|| !out_valid_q || result.ready);
	assign chars.ready = !valid_s1 || adv;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// Hold the accepted byte in the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			item_s1 <= chars.data;
		end
	end

	// Step the phase machine for one byte.
	always_comb begin
		c        = item_s1.char_in;
		pos      = bp_q;
		n_phase  = phase_q;
		n_sch    = sch_q;
		n_path   = path_q;
		n_qry    = qry_q;
		n_frag   = frag_q;
		n_scheme = fl_scheme_q;
		n_dslash = fl_dslash_q;
		n_long   = fl_long_q || (bp_q == MAX_POS);
		n_bp     = (bp_q == MAX_POS) ? bp_q : bp_q + PW'(1);
		to_path  = 1'b0;

		unique case (phase_q)
			PH_START: begin
				if (c == ucs_pkg::CH_SLASH) n_phase = PH_SLASH1;
				else if (ucs_pkg::is_alpha(c)) n_phase = PH_SCHEME;
				else to_path = 1'b1;
			end
			PH_SLASH1: begin
				if (c == ucs_pkg::CH_SLASH) begin
					n_scheme = 1'b1;
					n_dslash = 1'b1;
					n_sch    = '0;
					n_phase  = PH_AUTH;
				end else begin
					to_path = 1'b1;
				end
			end
			PH_SCHEME: begin
				if (ucs_pkg::is_scheme_char(c)) begin
					n_phase = PH_SCHEME;
				end else if (c == ucs_pkg::CH_COLON) begin
					n_scheme = 1'b1;
					n_sch    = n_bp;
					n_path   = n_bp;
					n_phase  = PH_AFTER0;
				end else begin
					to_path = 1'b1;
				end
			end
			PH_AFTER0: begin
				if (c == ucs_pkg::CH_SLASH) n_phase = PH_AFTER1;
				else to_path = 1'b1;
			end
			PH_AFTER1: begin
				if (c == ucs_pkg::CH_SLASH) begin
					n_dslash = 1'b1;
					n_phase  = PH_AUTH;
				end else begin
					to_path = 1'b1;
				end
			end
			PH_AUTH: begin
				if ((c == ucs_pkg::CH_SLASH) || (c == ucs_pkg::CH_QUEST)
					|| (c == ucs_pkg::CH_HASH)) begin
					n_path  = pos;
					to_path = 1'b1;
				end
			end
			PH_PATH: begin
				to_path = 1'b1;
			end
			PH_QUERY: begin
				if (c == ucs_pkg::CH_HASH) begin
					n_frag  = pos;
					n_phase = PH_FRAG;
				end
			end
			default: begin
				n_phase = phase_q;
			end
		endcase

		// Route a path byte: a question mark opens the query, a hash the fragment.
		if (to_path) begin
			n_phase = PH_PATH;
			if (c == ucs_pkg::CH_QUEST) begin
				n_qry   = pos;
				n_phase = PH_QUERY;
			end else if (c == ucs_pkg::CH_HASH) begin
				n_qry   = pos;
				n_frag  = pos;
				n_phase = PH_FRAG;
			end
		end
	end

	// Close the open components at the end of the URI and build the result.
	always_comb begin
		f_path = (n_phase == PH_AUTH) ? n_bp : n_path;
		f_qry  = ((n_phase != PH_QUERY) && (n_phase != PH_FRAG)) ? n_bp : n_qry;
		f_frag = (n_phase != PH_FRAG) ? n_bp : n_frag;
		f_auth = n_scheme && n_dslash
			&& ({1'b0, f_path} > ({1'b0, n_sch} + (PW+1)'(2)));

		fin.scheme_found      = n_scheme;
		fin.scheme_relative   = n_scheme && (n_sch == '0);
		fin.scheme_end        = ucs_pkg::OFF_W'(n_sch);
		fin.authority_present = f_auth;
		fin.path_start        = ucs_pkg::OFF_W'(f_path);
		fin.query_start       = ucs_pkg::OFF_W'(f_qry);
		fin.fragment_start    = ucs_pkg::OFF_W'(f_frag);
		fin.total_length      = ucs_pkg::OFF_W'(n_bp);
		fin.too_long          = n_long;
	end

	// Update the parse state; drop it at the end of each URI.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			bp_q        <= '0;
			sch_q       <= '0;
			path_q      <= '0;
			qry_q       <= '0;
			frag_q      <= '0;
			fl_scheme_q <= 1'b0;
			fl_dslash_q <= 1'b0;
			fl_long_q   <= 1'b0;
		end else if (adv) begin
			if (item_s1.empty_uri || item_s1.last_char) begin
				phase_q     <= PH_START;
				bp_q        <= '0;
				sch_q       <= '0;
				path_q      <= '0;
				qry_q       <= '0;
				frag_q      <= '0;
				fl_scheme_q <= 1'b0;
				fl_dslash_q <= 1'b0;
				fl_long_q   <= 1'b0;
			end else begin
				phase_q     <= n_phase;
				bp_q        <= n_bp;
				sch_q       <= n_sch;
				path_q      <= n_path;
				qry_q       <= n_qry;
				frag_q      <= n_frag;
				fl_scheme_q <= n_scheme;
				fl_dslash_q <= n_dslash;
				fl_long_q   <= n_long;
			end
		end
	end

	// Load the result register; release it once the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (adv && (item_s1.empty_uri || item_s1.last_char))
				|| (out_valid_q && !result.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (item_s1.empty_uri || item_s1.last_char)) begin
			out_q <= item_s1.empty_uri ? '0 : fin;
		end
	end

	`UCS_ASSERT_ALWAYS(a_pos_bound, bp_q <= MAX_POS, "byte position past MAX_LEN")
	`UCS_ASSERT_ALWAYS(a_long_sat, !fl_long_q || (bp_q == MAX_POS), "too long without saturation")
	`UCS_ASSERT_NEXT(a_end_clears, adv && (item_s1.last_char || item_s1.empty_uri),
		(phase_q == PH_START) && (bp_q == '0) && out_valid_q, "end of URI did not restart")
	`UCS_ASSERT_NEXT(a_empty_zero, adv && item_s1.empty_uri,
		(out_q.total_length == '0) && !out_q.scheme_found, "empty URI result not zero")
	`UCS_ASSERT_ALWAYS(a_ready_free, out_valid_q || chars.ready, "input stalled with no result")

endmodule

`default_nettype wire
